// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL of the tone generator.
// Define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check that a property holds at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a consequent holds in the cycle after its antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_HOLDS(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/sctg_pkg.sv =====
// ----------------------------------------------------------------------------
// sctg_pkg
// Shared constants and types of the cadenced sine tone generator.
// ----------------------------------------------------------------------------
package sctg_pkg;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;
    localparam int INC_W      = 16;
    localparam int AMP_W      = 15;
    localparam int COUNT_W    = 24;
    localparam int SAMPLE_W   = 16;
    localparam int MAG_W      = 16;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ON_SAMPLES  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_SAMPLES = 8'd3;

    localparam logic [INC_W-1:0]   PHASE_INC_RST   = 16'd4096;
    localparam logic [AMP_W-1:0]   AMPLITUDE_RST   = 15'd1000;
    localparam logic [COUNT_W-1:0] ON_SAMPLES_RST  = 24'd8000;
    localparam logic [COUNT_W-1:0] OFF_SAMPLES_RST = 24'd8000;
    localparam logic [COUNT_W-1:0] COUNT_MAX       = 24'hFFFFFF;

    // pi in Q30, used to build the quarter-wave table
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    // Control travelling with a sample down the pipeline
    typedef struct packed {
        logic valid;
        logic tone;
    } stage_ctl_t;

endpackage

// ===== design/sctg_ifs.sv =====
// ----------------------------------------------------------------------------
// sctg_ifs
// Valid/ready channels of the tone generator: tick in, sample out, config.
// ----------------------------------------------------------------------------
interface sctg_tick_if;
    logic valid;
    logic ready;
    logic alarm_on;

    modport source (output valid, output alarm_on, input ready);
    modport sink (input valid, input alarm_on, output ready);
endinterface

interface sctg_sample_if;
    import sctg_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] audio_sample;
    logic                       tone_active;

    modport source (output valid, output audio_sample, output tone_active, input ready);
    modport sink (input valid, input audio_sample, input tone_active, output ready);
endinterface

interface sctg_cfg_if;
    import sctg_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/sctg_cadence.sv =====
// ----------------------------------------------------------------------------
// sctg_cadence
// Tone/silence cadence, phase accumulator and the first pipeline register.
// ----------------------------------------------------------------------------
module sctg_cadence #(
    parameter int PHASE_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           take,
    input  logic                           load,
    input  logic [sctg_pkg::INC_W-1:0]     phase_inc,
    input  logic [sctg_pkg::COUNT_W-1:0]   on_samples,
    input  logic [sctg_pkg::COUNT_W-1:0]   off_samples,
    output sctg_pkg::stage_ctl_t           s1_ctl,
    output logic [PHASE_BITS-1:0]          s1_phase
);
    import sctg_pkg::*;

    logic [PHASE_BITS-1:0]       phase_reg;
    logic [PHASE_BITS-1:0]       phase_next;
    logic                        tone_reg;
    logic                        tone_next;
    logic [COUNT_W-1:0]          count_reg;
    logic [COUNT_W-1:0]          count_next;
    logic                        expired;
    logic                        tone_now;
    logic [COUNT_W-1:0]          count_base;
    logic [PHASE_BITS+INC_W-1:0] inc_wide;
    logic [PHASE_BITS-1:0]       inc_ext;
    logic                        s1_valid_reg;
    logic                        s1_tone_reg;
    logic [PHASE_BITS-1:0]       s1_phase_reg;

    // Fit the increment to the accumulator width (zero-extend or truncate)
    assign inc_wide = {{PHASE_BITS{1'b0}}, phase_inc};
    assign inc_ext  = inc_wide[PHASE_BITS-1:0];

    always_comb
    begin
        expired    = tone_reg ? (count_reg >= on_samples) : (count_reg >= off_samples);
        tone_now   = tone_reg ^ expired;
        count_base = expired ? '0 : count_reg;
        tone_next  = tone_reg;
        count_next = count_reg;
        phase_next = phase_reg;
        if (take)
        begin
            tone_next  = tone_now;
            count_next = (count_base == COUNT_MAX) ? COUNT_MAX
                                                   : COUNT_W'(count_base + 1'b1);
            if (tone_now)
            begin
                phase_next = phase_reg + inc_ext;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= '0;
            tone_reg     <= 1'b1;
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            tone_reg  <= tone_next;
            count_reg <= count_next;
            if (load)
            begin
                s1_valid_reg <= take;
            end
        end
    end

    // Hold the phase before the advance: the sample uses it
    always_ff @(posedge clk)
    begin
        if (load && take)
        begin
            s1_tone_reg  <= tone_now;
            s1_phase_reg <= phase_reg;
        end
    end

    assign s1_ctl.valid = s1_valid_reg;
    assign s1_ctl.tone  = s1_tone_reg;
    assign s1_phase     = s1_phase_reg;

endmodule

// ===== design/sctg_tone.sv =====
// ----------------------------------------------------------------------------
// sctg_tone
// Quarter-wave sine lookup and amplitude scaling, with the result register.
// ----------------------------------------------------------------------------
module sctg_tone #(
    parameter int PHASE_BITS       = 16,
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sctg_pkg::stage_ctl_t                s1_ctl,
    input  logic [PHASE_BITS-1:0]               s1_phase,
    input  logic [sctg_pkg::AMP_W-1:0]          amplitude,
    input  logic                                out_ready,
    output logic                                s2_load,
    output logic                                out_valid,
    output logic signed [sctg_pkg::SAMPLE_W-1:0] out_sample,
    output logic                                out_tone
);
    import sctg_pkg::*;

    localparam int POS_W  = $clog2(4 * SINE_TABLE_DEPTH);
    localparam int PROD_W = PHASE_BITS + POS_W;
    localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);
    localparam int J_W    = $clog2(SINE_TABLE_DEPTH + 1);

    typedef logic [MAG_W-1:0] lut_t [SINE_TABLE_DEPTH];

    // sin(pi/2 * k / depth) in Q15 by an odd Taylor series in Q30
    function automatic logic [MAG_W-1:0] sine_entry(longint unsigned k);
        longint unsigned x;
        longint unsigned t;
        longint          s;
        longint          r;
        x = (PI_Q30 * k) / (2 * SINE_TABLE_DEPTH);
        t = x;
        s = longint'(x);
        t = (t * x) >> 30; t = (t * x) >> 30; t = t / 6;   s = s - longint'(t);
        t = (t * x) >> 30; t = (t * x) >> 30; t = t / 20;  s = s + longint'(t);
        t = (t * x) >> 30; t = (t * x) >> 30; t = t / 42;  s = s - longint'(t);
        t = (t * x) >> 30; t = (t * x) >> 30; t = t / 72;  s = s + longint'(t);
        t = (t * x) >> 30; t = (t * x) >> 30; t = t / 110; s = s - longint'(t);
        t = (t * x) >> 30; t = (t * x) >> 30; t = t / 156; s = s + longint'(t);
        t = (t * x) >> 30; t = (t * x) >> 30; t = t / 210; s = s - longint'(t);
        if (s < 0)
        begin
            s = 0;
        end
        r = (s + 64'sd16384) >>> 15;
        if (r > 32768)
        begin
            r = 32768;
        end
        return MAG_W'(r);
    endfunction

    function automatic lut_t build_lut();
        lut_t tbl;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++)
        begin
            tbl[k] = sine_entry(longint'(k));
        end
        return tbl;
    endfunction

    localparam lut_t             SINE_LUT = build_lut();
    localparam logic [MAG_W-1:0] SINE_TOP = sine_entry(longint'(SINE_TABLE_DEPTH));

    logic [PROD_W-1:0]        pos_prod;
    logic [POS_W-1:0]         pos;
    logic [1:0]               quad;
    logic [POS_W-1:0]         offset;
    logic [J_W-1:0]           j;
    logic [MAG_W-1:0]         mag;
    logic                     s2_valid_reg;
    logic                     s2_tone_reg;
    logic                     s2_neg_reg;
    logic [MAG_W-1:0]         s2_mag_reg;
    logic                     s3_load;
    logic [MAG_W+AMP_W-1:0]   scaled;
    logic [SAMPLE_W-1:0]      mag_out;
    logic                     out_valid_reg;
    logic                     out_tone_reg;
    logic [SAMPLE_W-1:0]      out_sample_reg;

    // Table position: phase * 4 * depth over one turn
    assign pos_prod = {{POS_W{1'b0}}, s1_phase} * PROD_W'(4 * SINE_TABLE_DEPTH);
    assign pos      = pos_prod[PROD_W-1:PHASE_BITS];

    always_comb
    begin
        if (pos >= POS_W'(3 * SINE_TABLE_DEPTH))
        begin
            quad   = 2'd3;
            offset = POS_W'(3 * SINE_TABLE_DEPTH);
        end
        else if (pos >= POS_W'(2 * SINE_TABLE_DEPTH))
        begin
            quad   = 2'd2;
            offset = POS_W'(2 * SINE_TABLE_DEPTH);
        end
        else if (pos >= POS_W'(SINE_TABLE_DEPTH))
        begin
            quad   = 2'd1;
            offset = POS_W'(SINE_TABLE_DEPTH);
        end
        else
        begin
            quad   = 2'd0;
            offset = '0;
        end
        // Odd quadrants read the table backward
        j = J_W'(pos - offset);
        if (quad[0])
        begin
            j = J_W'(SINE_TABLE_DEPTH) - j;
        end
        mag = (j == J_W'(SINE_TABLE_DEPTH)) ? SINE_TOP : SINE_LUT[j[IDX_W-1:0]];
    end

    assign s3_load = !out_valid_reg || out_ready;
    assign s2_load = !s2_valid_reg || s3_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_load)
            begin
                s2_valid_reg <= s1_ctl.valid;
            end
            if (s3_load)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Silence drops the magnitude to zero
    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            s2_tone_reg <= s1_ctl.tone;
            s2_neg_reg  <= quad[1];
            s2_mag_reg  <= s1_ctl.tone ? mag : '0;
        end
    end

    assign scaled  = s2_mag_reg * {{MAG_W{1'b0}}, amplitude};
    assign mag_out = scaled[MAG_W+AMP_W-1:AMP_W];

    always_ff @(posedge clk)
    begin
        if (s3_load)
        begin
            out_tone_reg   <= s2_tone_reg;
            out_sample_reg <= s2_neg_reg ? (~mag_out + 1'b1) : mag_out;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_tone   = out_tone_reg;
    assign out_sample = $signed(out_sample_reg);

endmodule

// ===== design/cadenced_sine_tone_generator_unit.sv =====
// ----------------------------------------------------------------------------
// cadenced_sine_tone_generator_unit
// Alarm beeper: sine tone gated by an on/off cadence, one sample per ringing tick.
// A sample passes the cadence, lookup and output registers after its tick.
// Throughput: one tick per cycle unless the sample output is stalled.
// Ticks with alarm_on clear are taken like other ticks but produce no sample.
// Reset: phase 0, tone phase, count 0, registers to their default values.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cadenced_sine_tone_generator_unit #(
    parameter int PHASE_BITS       = 16,
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    sctg_tick_if.sink     tick,
    sctg_sample_if.source sample,
    sctg_cfg_if.sink      cfg
);
    import sctg_pkg::*;

    logic [INC_W-1:0]      phase_inc_reg;
    logic [AMP_W-1:0]      amplitude_reg;
    logic [COUNT_W-1:0]    on_samples_reg;
    logic [COUNT_W-1:0]    off_samples_reg;
    stage_ctl_t            s1_ctl;
    logic [PHASE_BITS-1:0] s1_phase;
    logic                  s1_load;
    logic                  s2_load;
    logic                  take;

    // Configuration writes are always accepted
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_inc_reg   <= PHASE_INC_RST;
            amplitude_reg   <= AMPLITUDE_RST;
            on_samples_reg  <= ON_SAMPLES_RST;
            off_samples_reg <= OFF_SAMPLES_RST;
        end
        else if (cfg.valid)
        begin
            // Drop writes to indexes outside the register list
            unique case (cfg.index)
                REG_PHASE_INC:   phase_inc_reg   <= cfg.data[INC_W-1:0];
                REG_AMPLITUDE:   amplitude_reg   <= cfg.data[AMP_W-1:0];
                REG_ON_SAMPLES:  on_samples_reg  <= cfg.data[COUNT_W-1:0];
                REG_OFF_SAMPLES: off_samples_reg <= cfg.data[COUNT_W-1:0];
                default:         ;
            endcase
        end
    end

    // First stage advances when it is empty or the lookup stage takes it
    assign s1_load    = !s1_ctl.valid || s2_load;
    assign tick.ready = s1_load;
    // Only ringing ticks touch the cadence and produce a sample
    assign take       = tick.valid && tick.ready && tick.alarm_on;

    sctg_cadence #(
        .PHASE_BITS (PHASE_BITS)
    ) u_cadence (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .load        (s1_load),
        .phase_inc   (phase_inc_reg),
        .on_samples  (on_samples_reg),
        .off_samples (off_samples_reg),
        .s1_ctl      (s1_ctl),
        .s1_phase    (s1_phase)
    );

    sctg_tone #(
        .PHASE_BITS       (PHASE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_tone (
        .clk        (clk),
        .rst_n      (rst_n),
        .s1_ctl     (s1_ctl),
        .s1_phase   (s1_phase),
        .amplitude  (amplitude_reg),
        .out_ready  (sample.ready),
        .s2_load    (s2_load),
        .out_valid  (sample.valid),
        .out_sample (sample.audio_sample),
        .out_tone   (sample.tone_active)
    );

    `ASSERT_HOLDS(a_silence_is_zero, clk, rst_n,
        sample.valid && !sample.tone_active |-> sample.audio_sample == '0,
        "silence sample is not zero")
    `ASSERT_HOLDS(a_no_negative_full_scale, clk, rst_n,
        sample.valid |-> sample.audio_sample != 16'h8000,
        "sample magnitude exceeds 32767")
    `ASSERT_HOLDS(a_stall_means_full, clk, rst_n,
        !tick.ready |-> sample.valid && !sample.ready,
        "tick stalled while the output is free")
    `ASSERT_NEXT(a_take_fills_stage, clk, rst_n, take, s1_ctl.valid,
        "ringing tick did not enter the pipeline")

endmodule

// ===== test/sctg_tone_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sctg_tone_checker
// Passive scoreboard for the tone generator. It mirrors the register file and
// the cadence/phase state, predicts one sample per ringing tick and compares
// each delivered sample field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module sctg_tone_checker
    import sctg_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    sctg_tick_if   tick,
    sctg_sample_if sample,
    sctg_cfg_if    cfg,
    output int     errors,
    output int     pending,
    output int     tone_count,
    output int     silence_count
);

    localparam int PHASE_W = 16;
    localparam int QUARTER = 256;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] audio_sample;
        logic                       tone_active;
    } tone_sample_t;

    logic [MAG_W-1:0]   quarter_sine [0:QUARTER];
    tone_sample_t       expected_samples [$];

    logic [INC_W-1:0]   phase_inc;
    logic [AMP_W-1:0]   amplitude;
    logic [COUNT_W-1:0] on_len;
    logic [COUNT_W-1:0] off_len;

    logic [PHASE_W-1:0] phase_acc;
    logic               in_tone;
    logic [COUNT_W-1:0] cadence_count;

    // Odd Taylor series of sin() through x^15 in Q30, rounded to Q15
    function automatic logic [MAG_W-1:0] sine_q15(input int k);
        longint unsigned kk;
        longint unsigned x;
        longint unsigned term;
        longint          acc;
        longint          rounded;
        kk = k;
        x = (PI_Q30 * kk) / (2 * QUARTER);
        term = x;
        acc = longint'(x);
        for (int n = 1; n <= 7; n++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        rounded = (acc + 16384) / 32768;
        if (rounded > 32768)
            rounded = 32768;
        return rounded[MAG_W-1:0];
    endfunction

    // Cadence decision, sample from the current phase, then advance
    function automatic tone_sample_t advance_tone();
        logic [9:0]       pos;
        logic [MAG_W-1:0] mag;
        logic [31:0]      scaled;
        tone_sample_t     res;
        if (in_tone && cadence_count >= on_len)
        begin
            in_tone = 1'b0;
            cadence_count = '0;
        end
        else if (!in_tone && cadence_count >= off_len)
        begin
            in_tone = 1'b1;
            cadence_count = '0;
        end
        res.tone_active = in_tone;
        res.audio_sample = '0;
        if (in_tone)
        begin
            // (phase * 4 * QUARTER) >> PHASE_W keeps the top ten phase bits
            pos = phase_acc[PHASE_W-1 -: 10];
            mag = pos[8] ? quarter_sine[QUARTER - int'(pos[7:0])] : quarter_sine[pos[7:0]];
            scaled = (32'(mag) * 32'(amplitude)) >> 15;
            res.audio_sample = pos[9] ? SAMPLE_W'(-scaled) : SAMPLE_W'(scaled);
            phase_acc = phase_acc + phase_inc;
        end
        if (cadence_count != COUNT_MAX)
            cadence_count = cadence_count + 1'b1;
        return res;
    endfunction

    initial
    begin
        for (int k = 0; k <= QUARTER; k++)
            quarter_sine[k] = sine_q15(k);
    end

    always @(posedge clk or negedge rst_n)
    begin
        tone_sample_t want;
        if (!rst_n)
        begin
            phase_inc     = PHASE_INC_RST;
            amplitude     = AMPLITUDE_RST;
            on_len        = ON_SAMPLES_RST;
            off_len       = OFF_SAMPLES_RST;
            phase_acc     = '0;
            in_tone       = 1'b1;
            cadence_count = '0;
            expected_samples.delete();
            errors        = 0;
            pending       = 0;
            tone_count    = 0;
            silence_count = 0;
        end
        else
        begin
            if (sample.valid && sample.ready)
            begin
                if (expected_samples.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected sample, expected none, got %0d (tone_active %0b)",
                             $time, $signed(sample.audio_sample), sample.tone_active);
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (sample.audio_sample !== want.audio_sample)
                    begin
                        errors++;
                        $display("%0t: audio_sample mismatch, expected %0d, got %0d",
                                 $time, $signed(want.audio_sample),
                                 $signed(sample.audio_sample));
                    end
                    if (sample.tone_active !== want.tone_active)
                    begin
                        errors++;
                        $display("%0t: tone_active mismatch, expected %0b, got %0b",
                                 $time, want.tone_active, sample.tone_active);
                    end
                    if (want.tone_active)
                        tone_count++;
                    else
                        silence_count++;
                end
            end

            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_PHASE_INC:   phase_inc = cfg.data[INC_W-1:0];
                    REG_AMPLITUDE:   amplitude = cfg.data[AMP_W-1:0];
                    REG_ON_SAMPLES:  on_len    = cfg.data[COUNT_W-1:0];
                    REG_OFF_SAMPLES: off_len   = cfg.data[COUNT_W-1:0];
                    default: ;
                endcase
            end

            if (tick.valid && tick.ready && tick.alarm_on)
                expected_samples.push_back(advance_tone());

            pending = expected_samples.size();
        end
    end

endmodule

// ===== test/cadenced_sine_tone_generator_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cadenced_sine_tone_generator_unit_test
// Drives ticks and register writes into the alarm tone generator with random
// gaps and output stalls; a side-by-side checker predicts every sample.
// ----------------------------------------------------------------------------
module cadenced_sine_tone_generator_unit_test;
    import sctg_pkg::*;

    // Allow a good margin beyond the sample latency so that silent ticks
    // still in flight are gone before a register write.
    localparam int TICK_LATENCY  = 3;
    localparam int SETTLE_CYCLES = 4 * TICK_LATENCY;
    localparam int RAND_PHASES   = 12;
    localparam int PHASE_TICKS   = 105;

    logic clk;
    logic rst_n;
    bit   no_stall;

    int mismatches;
    int awaiting;
    int tone_seen;
    int silence_seen;
    int ticks_sent;
    int settings_used;

    sctg_tick_if   tick ();
    sctg_sample_if sample ();
    sctg_cfg_if    cfg ();

    cadenced_sine_tone_generator_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick),
        .sample (sample),
        .cfg    (cfg)
    );

    sctg_tone_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .tick          (tick),
        .sample        (sample),
        .cfg           (cfg),
        .errors        (mismatches),
        .pending       (awaiting),
        .tone_count    (tone_seen),
        .silence_count (silence_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Backpressure on the sample side: stall with a chance of about 12 percent,
    // except while the no-stall stretch is running.
    always @(posedge clk)
    begin
        if (!rst_n)
            sample.ready <= 1'b0;
        else
            sample.ready <= no_stall || ($urandom_range(99) >= 12);
    end

    // Offer one tick transaction; idle at random first. Valid stays high on
    // return so back-to-back ticks need no second assignment in one step.
    task automatic send_tick(input bit ringing);
        while (!no_stall && $urandom_range(99) < 12)
        begin
            tick.valid <= 1'b0;
            @(posedge clk);
        end
        tick.valid    <= 1'b1;
        tick.alarm_on <= ringing;
        do
            @(posedge clk);
        while (!tick.ready);
        ticks_sent++;
    endtask

    // One register write transaction; the caller drops valid when done.
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        while (!no_stall && $urandom_range(99) < 12)
        begin
            cfg.valid <= 1'b0;
            @(posedge clk);
        end
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
    endtask

    // Drop tick valid, wait for every predicted sample, then let any silent
    // ticks still in the pipeline drain out.
    task automatic settle();
        tick.valid <= 1'b0;
        do
            @(posedge clk);
        while (awaiting != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Load all four registers, plus one write to an unused index that the
    // block must ignore. Data may carry junk above a register's width.
    task automatic program_regs(input logic [CFG_DATA_W-1:0] inc,
                                input logic [CFG_DATA_W-1:0] amp,
                                input logic [CFG_DATA_W-1:0] on_len,
                                input logic [CFG_DATA_W-1:0] off_len);
        write_cfg(REG_PHASE_INC, inc);
        write_cfg(REG_AMPLITUDE, amp);
        write_cfg(REG_ON_SAMPLES, on_len);
        write_cfg(REG_OFF_SAMPLES, off_len);
        write_cfg(CFG_IDX_W'($urandom_range(255, 4)), CFG_DATA_W'($urandom));
        cfg.valid <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        no_stall      = 1'b0;
        tick.valid    = 1'b0;
        tick.alarm_on = 1'b0;
        cfg.valid     = 1'b0;
        cfg.index     = '0;
        cfg.data      = '0;
        ticks_sent    = 0;
        settings_used = 1;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        settle();

        // Reset defaults: silent ticks must hold the phase, ringing ticks
        // walk it in quarter-of-a-quadrant steps.
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        settle();

        // Quarter-turn steps at full amplitude hit every quadrant including
        // both peaks; a short cadence flips between tone and silence.
        // Amplitude data is all ones, so the upper bits must be masked.
        program_regs(24'h004000, 24'hFFFFFF, 24'd3, 24'd2);
        repeat (12) send_tick(1'b1);
        settle();

        // Zero cadence lengths toggle the phase on every sample; the largest
        // increment with junk above bit 15 and the smallest nonzero amplitude.
        program_regs(24'hABFFFF, 24'd1, 24'd0, 24'd0);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b1);
        settle();

        // Random settings with random tick streams. Most cadences are short so
        // both phases repeat often; some settings sit at the extremes.
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            logic [CFG_DATA_W-1:0] inc;
            logic [CFG_DATA_W-1:0] amp;
            logic [CFG_DATA_W-1:0] on_len;
            logic [CFG_DATA_W-1:0] off_len;

            case ($urandom_range(5))
                0:       inc = '0;
                1:       inc = {8'($urandom), 16'hFFFF};
                default: inc = CFG_DATA_W'($urandom);
            endcase
            case ($urandom_range(5))
                0:       amp = '0;
                1:       amp = 24'h007FFF;
                default: amp = CFG_DATA_W'($urandom);
            endcase
            case ($urandom_range(7))
                0:       on_len = '0;
                default: on_len = CFG_DATA_W'($urandom_range(40, 1));
            endcase
            case ($urandom_range(7))
                0:       off_len = '0;
                default: off_len = CFG_DATA_W'($urandom_range(40, 1));
            endcase
            // Longest lengths: the tone, then the silence, never ends in range
            if (p == 3)
                on_len = COUNT_MAX;
            if (p == 4)
                off_len = COUNT_MAX;

            program_regs(inc, amp, on_len, off_len);
            // Run one whole setting without any idling on either side
            no_stall = (p == 6);
            repeat (PHASE_TICKS) send_tick($urandom_range(99) < 85);
            settle();
            no_stall = 1'b0;
        end

        $display("Sent %0d ticks under %0d register settings.", ticks_sent, settings_used);
        $display("Checked %0d tone and %0d silent samples, %0d mismatches.",
                 tone_seen, silence_seen, mismatches);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Hang guard: a correct run takes a small fraction of this
    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
